// ----- rtl/core/b32d_pkg.sv -----
// ----------------------------------------------------------------------------
// b32d_pkg
// Shared types, constants and helper functions for the Bech32 string decoder.
// ----------------------------------------------------------------------------
package b32d_pkg;

  localparam int unsigned MaxLenDefault = 63;

  typedef struct packed {
    logic [7:0] char_in;
    logic       is_final;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [2:0] status;
    logic       last_out;
  } out_item_t;

  localparam logic [1:0] KindPrefix = 2'd0;
  localparam logic [1:0] KindData   = 2'd1;
  localparam logic [1:0] KindStatus = 2'd2;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StLength   = 3'd1;
  localparam logic [2:0] StMixed    = 3'd2;
  localparam logic [2:0] StSep      = 3'd3;
  localparam logic [2:0] StPrefix   = 3'd4;
  localparam logic [2:0] StData     = 3'd5;
  localparam logic [2:0] StChecksum = 3'd6;
  localparam logic [2:0] StOverflow = 3'd7;

  typedef enum logic [3:0] {
    S_LOAD,
    S_CHECK,
    S_PRE_CHK,
    S_HI_POLY,
    S_ZERO_POLY,
    S_LO_POLY,
    S_DATA_POLY,
    S_VERDICT,
    S_EMIT_PRE,
    S_EMIT_DATA,
    S_EMIT_STAT
  } state_e;

  // Walk phases the datapath understands.
  typedef enum logic [2:0] {
    PH_NONE,
    PH_PRE_CHK,
    PH_HI,
    PH_ZERO,
    PH_LO,
    PH_DATA,
    PH_EMIT_PRE,
    PH_EMIT_DATA
  } phase_e;

  typedef struct packed {
    logic       load;        // store accepted char
    logic       clear;       // return to reset values
    logic       ptr_start;   // restart read pointer at phase start
    phase_e     phase;
    logic       rd_en;       // a memory read is issued this cycle
    logic       out_load;    // load output register
    logic [1:0] out_kind;
    logic [2:0] out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic       overflowed;
    logic       short_len;
    logic       mixed;
    logic       sep_bad;
    logic       walk_done;   // read pointer reached end of current phase
    logic       proc_busy;   // a read is still in flight
    logic       bad_pre;
    logic       bad_data;
    logic       chk_ok;
    logic       has_prefix;
    logic       has_payload;
  } dp_stat_t;

  localparam logic [29:0] Gen0 = 30'h3b6a57b2;
  localparam logic [29:0] Gen1 = 30'h26508e6d;
  localparam logic [29:0] Gen2 = 30'h1ea119fa;
  localparam logic [29:0] Gen3 = 30'h3d4233dd;
  localparam logic [29:0] Gen4 = 30'h2a1462b3;

  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) r = c + 8'd32;
    return r;
  endfunction

  // Returns {invalid, symbol}.
  function automatic logic [5:0] symbol_of(input logic [7:0] c);
    logic [7:0] f;
    logic [5:0] r;
    f = fold_lower(c);
    case (f)
      "q": r = 6'd0;   "p": r = 6'd1;   "z": r = 6'd2;   "r": r = 6'd3;
      "y": r = 6'd4;   "9": r = 6'd5;   "x": r = 6'd6;   "8": r = 6'd7;
      "g": r = 6'd8;   "f": r = 6'd9;   "2": r = 6'd10;  "t": r = 6'd11;
      "v": r = 6'd12;  "d": r = 6'd13;  "w": r = 6'd14;  "0": r = 6'd15;
      "s": r = 6'd16;  "3": r = 6'd17;  "j": r = 6'd18;  "n": r = 6'd19;
      "5": r = 6'd20;  "4": r = 6'd21;  "k": r = 6'd22;  "h": r = 6'd23;
      "c": r = 6'd24;  "e": r = 6'd25;  "6": r = 6'd26;  "m": r = 6'd27;
      "u": r = 6'd28;  "a": r = 6'd29;  "7": r = 6'd30;  "l": r = 6'd31;
      default: r = 6'd32;
    endcase
    return r;
  endfunction

  function automatic logic [29:0] poly_step(input logic [29:0] chk, input logic [4:0] v);
    logic [29:0] r;
    logic [4:0]  top;
    top = chk[29:25];
    r = {chk[24:0], v};
    if (top[0]) r = r ^ Gen0;
    if (top[1]) r = r ^ Gen1;
    if (top[2]) r = r ^ Gen2;
    if (top[3]) r = r ^ Gen3;
    if (top[4]) r = r ^ Gen4;
    return r;
  endfunction

endpackage

// ----- rtl/core/b32d_datapath.sv -----
// ----------------------------------------------------------------------------
// b32d_datapath
// Character store, load-time flags, read pointer, checksum and output register.
// ----------------------------------------------------------------------------
module b32d_datapath #(
  parameter int unsigned MaxLen = b32d_pkg::MaxLenDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  b32d_pkg::in_item_t  in_data_i,
  input  b32d_pkg::dp_cmd_t   cmd_i,
  output b32d_pkg::dp_stat_t  stat_o,
  output b32d_pkg::out_item_t out_data_o
);

  localparam int unsigned AW = $clog2(MaxLen);
  localparam int unsigned CW = $clog2(MaxLen + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MaxLen);

  logic [7:0] mem_q [MaxLen];
  logic [7:0] rd_q;

  logic [CW-1:0] cnt_q, cnt_d;
  logic          lower_q, lower_d, upper_q, upper_d, ovf_q, ovf_d;
  logic          sep_v_q, sep_v_d;
  logic [CW-1:0] sep_q, sep_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic          rd_v_q;
  b32d_pkg::phase_e rd_ph_q;
  logic [29:0]   chk_q, chk_d;
  logic          bad_pre_q, bad_pre_d, bad_data_q, bad_data_d;
  b32d_pkg::out_item_t out_q, out_d;

  logic [CW-1:0] ph_start, ph_end;
  logic [7:0]    c_in, fl;
  logic [5:0]    sym;

  assign c_in = in_data_i.char_in;

  always_comb begin
    ph_start = '0;
    ph_end   = sep_q;
    case (cmd_i.phase)
      b32d_pkg::PH_DATA: begin
        ph_start = sep_q + CW'(1);
        ph_end   = cnt_q;
      end
      b32d_pkg::PH_EMIT_DATA: begin
        ph_start = sep_q + CW'(1);
        ph_end   = cnt_q - CW'(6);
      end
      default: begin
        ph_start = '0;
        ph_end   = sep_q;
      end
    endcase
  end

  always_comb begin
    cnt_d   = cnt_q;
    lower_d = lower_q;
    upper_d = upper_q;
    ovf_d   = ovf_q;
    sep_v_d = sep_v_q;
    sep_d   = sep_q;
    if (cmd_i.clear) begin
      cnt_d = '0; lower_d = 1'b0; upper_d = 1'b0; ovf_d = 1'b0;
      sep_v_d = 1'b0; sep_d = '0;
    end else if (cmd_i.load) begin
      if (cnt_q >= MaxCnt) begin
        ovf_d = 1'b1;
      end else begin
        if (c_in >= 8'h61 && c_in <= 8'h7a) lower_d = 1'b1;
        else if (c_in >= 8'h41 && c_in <= 8'h5a) upper_d = 1'b1;
        if (c_in == 8'h31) begin
          sep_v_d = 1'b1;
          sep_d   = cnt_q;
        end
        cnt_d = cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && cnt_q < MaxCnt) mem_q[cnt_q[AW-1:0]] <= c_in;
    if (cmd_i.rd_en) rd_q <= mem_q[ptr_q[AW-1:0]];
  end

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.ptr_start) ptr_d = ph_start;
    else if (cmd_i.rd_en) ptr_d = ptr_q + CW'(1);
  end

  assign fl  = b32d_pkg::fold_lower(rd_q);
  assign sym = b32d_pkg::symbol_of(rd_q);

  always_comb begin
    chk_d      = chk_q;
    bad_pre_d  = bad_pre_q;
    bad_data_d = bad_data_q;
    out_d      = out_q;
    if (cmd_i.clear) begin
      chk_d = 30'd1; bad_pre_d = 1'b0; bad_data_d = 1'b0;
    end else begin
      if (cmd_i.phase == b32d_pkg::PH_ZERO) chk_d = b32d_pkg::poly_step(chk_q, 5'd0);
      if (rd_v_q) begin
        case (rd_ph_q)
          b32d_pkg::PH_PRE_CHK: if (rd_q < 8'd33 || rd_q > 8'd126) bad_pre_d = 1'b1;
          b32d_pkg::PH_HI:      chk_d = b32d_pkg::poly_step(chk_q, {2'b00, fl[7:5]});
          b32d_pkg::PH_LO:      chk_d = b32d_pkg::poly_step(chk_q, fl[4:0]);
          b32d_pkg::PH_DATA: begin
            if (sym[5]) bad_data_d = 1'b1;
            chk_d = b32d_pkg::poly_step(chk_q, sym[4:0]);
          end
          default: ;
        endcase
      end
    end
    if (rd_v_q && rd_ph_q == b32d_pkg::PH_EMIT_PRE) begin
      out_d = '{kind: b32d_pkg::KindPrefix, value: fl, status: b32d_pkg::StOk,
                last_out: 1'b0};
    end else if (rd_v_q && rd_ph_q == b32d_pkg::PH_EMIT_DATA) begin
      out_d = '{kind: b32d_pkg::KindData, value: {3'b000, sym[4:0]},
                status: b32d_pkg::StOk, last_out: 1'b0};
    end else if (cmd_i.out_load) begin
      out_d = '{kind: cmd_i.out_kind, value: 8'd0, status: cmd_i.out_status,
                last_out: 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; lower_q <= 1'b0; upper_q <= 1'b0; ovf_q <= 1'b0;
      sep_v_q <= 1'b0; sep_q <= '0; ptr_q <= '0; rd_v_q <= 1'b0;
      rd_ph_q <= b32d_pkg::PH_NONE; chk_q <= 30'd1;
      bad_pre_q <= 1'b0; bad_data_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d; lower_q <= lower_d; upper_q <= upper_d; ovf_q <= ovf_d;
      sep_v_q <= sep_v_d; sep_q <= sep_d; ptr_q <= ptr_d;
      rd_v_q <= cmd_i.rd_en; rd_ph_q <= cmd_i.phase;
      chk_q <= chk_d; bad_pre_q <= bad_pre_d; bad_data_q <= bad_data_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_data_o = out_q;

  // Status flags: load-time checks, walk end and last read retired, check results.
  always_comb begin
    stat_o.overflowed  = ovf_q;
    stat_o.short_len   = cnt_q < CW'(8);
    stat_o.mixed       = lower_q && upper_q;
    stat_o.sep_bad     = !sep_v_q || sep_q == '0 ||
                         ({1'b0, sep_q} + (CW+1)'(7)) > {1'b0, cnt_q};
    stat_o.walk_done   = ptr_q >= ph_end;
    stat_o.proc_busy   = rd_v_q;
    stat_o.bad_pre     = bad_pre_q;
    stat_o.bad_data    = bad_data_q;
    stat_o.chk_ok      = chk_q == 30'd1;
    stat_o.has_prefix  = sep_q != '0;
    stat_o.has_payload = (sep_q + CW'(7)) < cnt_q;
  end

endmodule

// ----- rtl/core/b32d_ctrl.sv -----
// ----------------------------------------------------------------------------
// b32d_ctrl
// Sequencer: load, validation walks, emission walks and status result.
// ----------------------------------------------------------------------------
module b32d_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_final_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  b32d_pkg::dp_stat_t stat_i,
  output b32d_pkg::dp_cmd_t  cmd_o
);

  b32d_pkg::state_e state_q, state_d;
  logic             first_q, first_d;   // first cycle of a walk phase
  logic             ov_q, ov_d;         // output register holds a transaction
  logic [2:0]       st_q, st_d;
  logic             out_free;
  logic             emit_pend_q;

  assign out_free = !ov_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    first_d = 1'b0;
    st_d    = st_q;
    case (state_q)
      b32d_pkg::S_LOAD:
        if (in_valid_i && in_final_i) state_d = b32d_pkg::S_CHECK;
      b32d_pkg::S_CHECK: begin
        first_d = 1'b1;
        if (stat_i.overflowed) begin
          st_d = b32d_pkg::StOverflow; state_d = b32d_pkg::S_EMIT_STAT;
        end else if (stat_i.short_len) begin
          st_d = b32d_pkg::StLength; state_d = b32d_pkg::S_EMIT_STAT;
        end else if (stat_i.mixed) begin
          st_d = b32d_pkg::StMixed; state_d = b32d_pkg::S_EMIT_STAT;
        end else if (stat_i.sep_bad) begin
          st_d = b32d_pkg::StSep; state_d = b32d_pkg::S_EMIT_STAT;
        end else begin
          st_d = b32d_pkg::StOk; state_d = b32d_pkg::S_PRE_CHK;
        end
      end
      b32d_pkg::S_PRE_CHK:
        if (!first_q && stat_i.walk_done && !stat_i.proc_busy) begin
          first_d = 1'b1;
          state_d = b32d_pkg::S_HI_POLY;
        end
      b32d_pkg::S_HI_POLY:
        if (!first_q && stat_i.walk_done && !stat_i.proc_busy) begin
          state_d = b32d_pkg::S_ZERO_POLY;
        end
      b32d_pkg::S_ZERO_POLY: begin
        first_d = 1'b1;
        state_d = b32d_pkg::S_LO_POLY;
      end
      b32d_pkg::S_LO_POLY:
        if (!first_q && stat_i.walk_done && !stat_i.proc_busy) begin
          first_d = 1'b1;
          state_d = b32d_pkg::S_DATA_POLY;
        end
      // Data walk checks symbols and finishes the checksum.
      b32d_pkg::S_DATA_POLY:
        if (!first_q && stat_i.walk_done && !stat_i.proc_busy) begin
          state_d = b32d_pkg::S_VERDICT;
        end
      b32d_pkg::S_VERDICT: begin
        first_d = 1'b1;
        if (stat_i.bad_pre) begin
          st_d = b32d_pkg::StPrefix; state_d = b32d_pkg::S_EMIT_STAT;
        end else if (stat_i.bad_data) begin
          st_d = b32d_pkg::StData; state_d = b32d_pkg::S_EMIT_STAT;
        end else if (!stat_i.chk_ok) begin
          st_d = b32d_pkg::StChecksum; state_d = b32d_pkg::S_EMIT_STAT;
        end else if (stat_i.has_prefix) begin
          state_d = b32d_pkg::S_EMIT_PRE;
        end else if (stat_i.has_payload) begin
          state_d = b32d_pkg::S_EMIT_DATA;
        end else begin
          state_d = b32d_pkg::S_EMIT_STAT;
        end
      end
      b32d_pkg::S_EMIT_PRE:
        if (!first_q && stat_i.walk_done && !stat_i.proc_busy && out_free) begin
          first_d = 1'b1;
          state_d = stat_i.has_payload ? b32d_pkg::S_EMIT_DATA : b32d_pkg::S_EMIT_STAT;
        end
      b32d_pkg::S_EMIT_DATA:
        if (!first_q && stat_i.walk_done && !stat_i.proc_busy && out_free) begin
          state_d = b32d_pkg::S_EMIT_STAT;
        end
      b32d_pkg::S_EMIT_STAT:
        if (out_free) state_d = b32d_pkg::S_LOAD;
      default: ;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o = '0;
    cmd_o.phase = b32d_pkg::PH_NONE;
    cmd_o.out_kind = b32d_pkg::KindStatus;
    cmd_o.out_status = st_q;
    in_stall_o = 1'b1;
    case (state_q)
      b32d_pkg::S_LOAD: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      b32d_pkg::S_PRE_CHK: begin
        cmd_o.phase = b32d_pkg::PH_PRE_CHK;
        cmd_o.ptr_start = first_q;
        cmd_o.rd_en = !first_q && !stat_i.walk_done;
      end
      b32d_pkg::S_DATA_POLY: begin
        cmd_o.phase = b32d_pkg::PH_DATA;
        cmd_o.ptr_start = first_q;
        cmd_o.rd_en = !first_q && !stat_i.walk_done;
      end
      b32d_pkg::S_HI_POLY: begin
        cmd_o.phase = b32d_pkg::PH_HI;
        cmd_o.ptr_start = first_q;
        cmd_o.rd_en = !first_q && !stat_i.walk_done;
      end
      b32d_pkg::S_ZERO_POLY: cmd_o.phase = b32d_pkg::PH_ZERO;
      b32d_pkg::S_LO_POLY: begin
        cmd_o.phase = b32d_pkg::PH_LO;
        cmd_o.ptr_start = first_q;
        cmd_o.rd_en = !first_q && !stat_i.walk_done;
      end
      // One read in flight at most, so the output register is free when it lands.
      b32d_pkg::S_EMIT_PRE: begin
        cmd_o.phase = b32d_pkg::PH_EMIT_PRE;
        cmd_o.ptr_start = first_q;
        cmd_o.rd_en = !first_q && !stat_i.walk_done && !stat_i.proc_busy && out_free;
      end
      b32d_pkg::S_EMIT_DATA: begin
        cmd_o.phase = b32d_pkg::PH_EMIT_DATA;
        cmd_o.ptr_start = first_q;
        cmd_o.rd_en = !first_q && !stat_i.walk_done && !stat_i.proc_busy && out_free;
      end
      b32d_pkg::S_EMIT_STAT: begin
        cmd_o.out_load = out_free;
        cmd_o.clear = out_free;
      end
      default: ;
    endcase
  end

  // Output valid follows what lands in the output register.
  always_comb begin
    ov_d = ov_q;
    if (!out_stall_i) ov_d = 1'b0;
    if (emit_pend_q || cmd_o.out_load) ov_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= b32d_pkg::S_LOAD;
      first_q <= 1'b0;
      ov_q <= 1'b0;
      st_q <= b32d_pkg::StOk;
      emit_pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
      ov_q <= ov_d;
      st_q <= st_d;
      emit_pend_q <= cmd_o.rd_en && (cmd_o.phase == b32d_pkg::PH_EMIT_PRE ||
                                     cmd_o.phase == b32d_pkg::PH_EMIT_DATA);
    end
  end

  assign out_valid_o = ov_q;

endmodule

// ----- rtl/core/bech32_string_decoder_core.sv -----
// ----------------------------------------------------------------------------
// bech32_string_decoder_core
// Bech32 string decoder: buffers one string, validates, emits prefix/payload/status.
// ----------------------------------------------------------------------------
// Sequence: one character per cycle while loading; after the final one, a
// check step, four store walks (prefix range, checksum high, checksum low,
// data) with a zero step after the high walk, a verdict step, then one
// result per prefix character or payload symbol and finally the status.
// Throughput: one string at a time; input stalls until its status is registered.
// Reset: asynchronous, active low; control state clears, store is unset.
module bech32_string_decoder_core #(
  parameter int unsigned MaxLen = b32d_pkg::MaxLenDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  b32d_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output b32d_pkg::out_item_t out_data_o
);

  b32d_pkg::dp_cmd_t  cmd;
  b32d_pkg::dp_stat_t stat;

  b32d_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_final_i (in_data_i.is_final),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  b32d_datapath #(.MaxLen(MaxLen)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule
